>>> hdl/abre_pkg.sv
// Shared types and constants for the adaptive binary range encoder.
`default_nettype none

package abre_pkg;

  // Item kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_BIT     = 2'd0,
    OP_LITERAL = 2'd1,
    OP_MATCHED = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_UPD,
    ST_NORM,
    ST_FLUSH,
    ST_FINISH
  } state_e;

  localparam int unsigned PROB_BITS     = 11;
  localparam int unsigned ADAPT_SHIFT   = 5;
  localparam int unsigned IDX_W         = 13;
  localparam int unsigned OFF_W         = 10;
  localparam logic [11:0] PROB_ONE      = 12'd2048;
  localparam logic [10:0] PROB_INIT     = 11'd1024;
  localparam logic [31:0] TOP_VALUE     = 32'h0100_0000;
  localparam logic [31:0] RANGE_INIT    = 32'hFFFF_FFFF;
  localparam logic [9:0]  MATCH_OFFS    = 10'h100;
  localparam logic [3:0]  MAX_RES       = 4'd8;
  localparam logic [1:0]  LAST_GUARD    = 2'd3;
  localparam logic [2:0]  LAST_FLUSH    = 3'd4;
  localparam logic [2:0]  LAST_TREE_BIT = 3'd7;

  // Requests from the sequencer to the low/output unit.
  typedef struct packed {
    logic        add;
    logic [31:0] bound;
    logic        shift;
    logic        finish;
  } emit_cmd_t;

  // Status back from the low/output unit.
  typedef struct packed {
    logic stall;
    logic done;
    logic held_v;
  } emit_status_t;

endpackage

`default_nettype wire

>>> hdl/abre_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module abre_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/abre_emit.sv
// Low register, cache byte, pending count and output words of the range encoder.
`default_nettype none

module abre_emit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire abre_pkg::emit_cmd_t   cmd_i,
  output abre_pkg::emit_status_t     status_o,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [47:0]                m_tdata_o,  // lead_byte, fill_byte, fill_count
  output logic                       m_tlast_o
);

  logic [32:0] low_q, low_d;
  logic [7:0]  cache_q, cache_d;
  logic [31:0] pend_q, pend_d;
  logic [3:0]  res_cnt_q, res_cnt_d;
  logic        held_v_q, held_v_d;
  logic [47:0] held_q, held_d;
  logic        out_v_q, out_v_d;
  logic [47:0] out_q, out_d;
  logic        out_last_q, out_last_d;

  logic        carry;
  logic        resolve;
  logic        do_emit;
  logic        out_free;
  logic        stall;
  logic        shift_go;
  logic        finish_go;
  logic [47:0] new_word;

  assign carry    = low_q[32];
  assign resolve  = (low_q[31:24] != 8'hFF) || carry;
  assign do_emit  = resolve && (res_cnt_q < abre_pkg::MAX_RES);
  assign out_free = !out_v_q || m_tready_i;
  assign stall    = do_emit && held_v_q && !out_free;
  assign shift_go = cmd_i.shift && !stall;
  assign finish_go = cmd_i.finish && (!held_v_q || out_free);

  assign new_word = {pend_q - 32'd1, (carry ? 8'h00 : 8'hFF), cache_q + {7'd0, carry}};

  always_comb begin
    low_d      = low_q;
    cache_d    = cache_q;
    pend_d     = pend_q;
    res_cnt_d  = res_cnt_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;

    if (m_tready_i) begin
      out_v_d = 1'b0;
    end

    if (cmd_i.add) begin
      low_d = low_q + {1'b0, cmd_i.bound};
    end

    if (shift_go) begin
      low_d = {1'b0, low_q[23:0], 8'h00};
      if (resolve) begin
        cache_d = low_q[31:24];
        pend_d  = 32'd1;
      end else if (pend_q != 32'hFFFF_FFFF) begin
        pend_d = pend_q + 32'd1;
      end
      if (do_emit) begin
        // The word already held is not the item's last one: send it on.
        if (held_v_q) begin
          out_v_d    = 1'b1;
          out_d      = held_q;
          out_last_d = 1'b0;
        end
        held_v_d  = 1'b1;
        held_d    = new_word;
        res_cnt_d = res_cnt_q + 4'd1;
      end
    end

    if (finish_go) begin
      if (held_v_q) begin
        out_v_d    = 1'b1;
        out_d      = held_q;
        out_last_d = 1'b1;
      end
      held_v_d  = 1'b0;
      res_cnt_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= 33'd0;
      cache_q   <= 8'd0;
      pend_q    <= 32'd1;
      res_cnt_q <= 4'd0;
      held_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      low_q     <= low_d;
      cache_q   <= cache_d;
      pend_q    <= pend_d;
      res_cnt_q <= res_cnt_d;
      held_v_q  <= held_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign status_o.stall  = stall;
  assign status_o.done   = !held_v_q || out_free;
  assign status_o.held_v = held_v_q;

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/adaptive_binary_range_encoder_top.sv
// Top level of the adaptive binary range encoder: sequencer, range register and probability store.
`default_nettype none

// LZMA-style adaptive binary range encoder. Each input word codes one bit at a
// probability entry, a literal byte through an eight-level binary tree, or a
// literal matched against a match byte; a flush word performs five low shifts.
// Each normalisation shift that resolves the cached byte, up to eight per
// input word, yields one output word holding the lead byte, the fill byte and
// the number of fill bytes that follow it; tlast marks the last output word of
// an input word, and an input word may yield none. After reset the block
// sweeps the probability memory, one entry per cycle, setting every entry to
// the half-way probability; no input word is accepted during the sweep. Each
// coded bit goes round the loop through the probability memory (multiply,
// then update and write-back with the next read issued), followed by the
// normalisation shifts it needs. Before the first read, the probability index
// is reduced modulo PROB_ENTRIES by repeated subtraction (up to 7 subtractions
// when PROB_ENTRIES is 1024). Shifts also wait while the output register is
// full and a further output word is due.
module adaptive_binary_range_encoder_top #(
  parameter int unsigned PROB_ENTRIES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,  // bit_value, symbol, match_byte, prob_index, zero pad
  input  wire logic [1:0]  s_tuser_i,  // op
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [47:0]      m_tdata_o,  // lead_byte, fill_byte, fill_count
  output logic             m_tlast_o
);

  // Address width of the probability store, and a sum width that holds both
  // the raw index and a tree address before its wrap.
  localparam int unsigned AW = $clog2(PROB_ENTRIES);
  localparam int unsigned XW = (AW + 1 > abre_pkg::IDX_W) ? AW + 1 : abre_pkg::IDX_W;
  localparam int unsigned IW = abre_pkg::IDX_W;
  localparam int unsigned OFF_W_L = abre_pkg::OFF_W;

  abre_pkg::state_e state_q, state_d;

  // Input word unpacking.
  logic                       in_bit_value;
  logic [7:0]                 in_symbol;
  logic [7:0]                 in_match_byte;
  logic [abre_pkg::IDX_W-1:0] in_prob_index;
  abre_pkg::op_e              in_op;

  assign in_bit_value  = s_tdata_i[0];
  assign in_symbol     = s_tdata_i[8:1];
  assign in_match_byte = s_tdata_i[16:9];
  assign in_prob_index = s_tdata_i[29:17];
  assign in_op         = abre_pkg::op_e'(s_tuser_i);

  // Per-item registers. The tree walk keeps the remaining symbol and match
  // bits left-aligned so that bit 7 is always the bit being coded.
  logic [abre_pkg::IDX_W-1:0] red_q, red_d;
  logic                       single_q, single_d;
  logic                       bitv_q, bitv_d;
  logic [7:0]                 sym_q, sym_d;
  logic [7:0]                 mb_q, mb_d;
  logic [7:0]                 node_q, node_d;
  logic                       offs_q, offs_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       more_q;
  logic [1:0]                 guard_q;
  logic [2:0]                 flush_cnt_q;
  logic [AW-1:0]              clr_q;
  logic [AW-1:0]              cur_addr_q;

  // Coder state and the registered product.
  logic [31:0] range_q, range_d;
  logic [31:0] bound_q;

  // Memory port signals.
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [abre_pkg::PROB_BITS-1:0] rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [abre_pkg::PROB_BITS-1:0] wr_data;

  // Sequencer controls.
  logic load;
  logic advance;
  logic red_sub;
  logic upd;
  logic shift_go;

  abre_pkg::emit_cmd_t    emit_cmd;
  abre_pkg::emit_status_t emit_status;

  // Datapath terms.
  logic                          red_ge;
  logic                          last_bit;
  logic                          b_cur;
  logic [OFF_W_L-1:0]            off;
  logic [XW-1:0]                 addr_sum;
  logic [XW-1:0]                 addr_wrap;
  logic [31:0]                   prod;
  logic [31:0]                   range_upd;
  logic [31:0]                   range_sh;
  logic [abre_pkg::PROB_BITS-1:0] p_new;
  logic [11:0]                   p_gap;

  assign red_ge   = XW'(red_q) >= XW'(PROB_ENTRIES);
  assign last_bit = single_q || (cnt_q == abre_pkg::LAST_TREE_BIT);
  assign b_cur    = single_q ? bitv_q : sym_q[7];

  // Per-item register next values: loaded on acceptance, advanced one tree
  // level per coded bit. The matched offset stays on only while each coded
  // bit agrees with the match byte.
  always_comb begin
    red_d    = red_q;
    single_d = single_q;
    bitv_d   = bitv_q;
    sym_d    = sym_q;
    mb_d     = mb_q;
    node_d   = node_q;
    offs_d   = offs_q;
    cnt_d    = cnt_q;
    if (load) begin
      red_d    = in_prob_index;
      single_d = (in_op == abre_pkg::OP_BIT);
      bitv_d   = in_bit_value;
      sym_d    = in_symbol;
      mb_d     = in_match_byte;
      node_d   = 8'd1;
      offs_d   = (in_op == abre_pkg::OP_MATCHED);
      cnt_d    = 3'd0;
    end else if (red_sub) begin
      red_d = red_q - IW'(PROB_ENTRIES);
    end else if (advance) begin
      sym_d  = {sym_q[6:0], 1'b0};
      mb_d   = {mb_q[6:0], 1'b0};
      node_d = {node_q[6:0], b_cur};
      offs_d = offs_q && (mb_q[7] == b_cur);
      cnt_d  = cnt_q + 3'd1;
    end
  end

  // Address of the next bit to be read, taken from the next register values
  // so that a read can be issued in the same cycle as the advance.
  always_comb begin
    if (single_d) begin
      off = '0;
    end else begin
      off = {2'b00, node_d}
          + (offs_d ? abre_pkg::MATCH_OFFS : '0)
          + ((offs_d && mb_d[7]) ? abre_pkg::MATCH_OFFS : '0);
    end
    addr_sum  = XW'(red_q) + XW'(off);
    addr_wrap = (addr_sum >= XW'(PROB_ENTRIES)) ? addr_sum - XW'(PROB_ENTRIES) : addr_sum;
    rd_addr   = addr_wrap[AW-1:0];
  end

  // Split of the range and adaptation of the probability.
  assign prod      = {11'd0, range_q[31:abre_pkg::PROB_BITS]} * {21'd0, rd_data};
  assign range_upd = b_cur ? range_q - bound_q : bound_q;
  assign range_sh  = {range_q[23:0], 8'h00};
  assign p_gap     = (abre_pkg::PROB_ONE - {1'b0, rd_data}) >> abre_pkg::ADAPT_SHIFT;

  always_comb begin
    if (b_cur) begin
      p_new = rd_data - (rd_data >> abre_pkg::ADAPT_SHIFT);
    end else begin
      p_new = rd_data + p_gap[abre_pkg::PROB_BITS-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      abre_pkg::ST_CLEAR: begin
        if (clr_q == AW'(PROB_ENTRIES - 1)) begin
          state_d = abre_pkg::ST_IDLE;
        end
      end
      abre_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = (in_op == abre_pkg::OP_FLUSH) ? abre_pkg::ST_FLUSH : abre_pkg::ST_REDUCE;
        end
      end
      abre_pkg::ST_REDUCE: begin
        if (!red_ge) begin
          state_d = abre_pkg::ST_MUL;
        end
      end
      abre_pkg::ST_MUL: begin
        state_d = abre_pkg::ST_UPD;
      end
      abre_pkg::ST_UPD: begin
        if (range_upd < abre_pkg::TOP_VALUE) begin
          state_d = abre_pkg::ST_NORM;
        end else if (last_bit) begin
          state_d = abre_pkg::ST_FINISH;
        end else begin
          state_d = abre_pkg::ST_MUL;
        end
      end
      abre_pkg::ST_NORM: begin
        if (!emit_status.stall) begin
          if ((range_sh < abre_pkg::TOP_VALUE) && (guard_q != abre_pkg::LAST_GUARD)) begin
            state_d = abre_pkg::ST_NORM;
          end else if (more_q) begin
            state_d = abre_pkg::ST_MUL;
          end else begin
            state_d = abre_pkg::ST_FINISH;
          end
        end
      end
      abre_pkg::ST_FLUSH: begin
        if (!emit_status.stall && (flush_cnt_q == abre_pkg::LAST_FLUSH)) begin
          state_d = abre_pkg::ST_FINISH;
        end
      end
      abre_pkg::ST_FINISH: begin
        if (emit_status.done) begin
          state_d = abre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = abre_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready_o      = 1'b0;
    load            = 1'b0;
    red_sub         = 1'b0;
    advance         = 1'b0;
    upd             = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = cur_addr_q;
    wr_data         = p_new;
    emit_cmd.add    = 1'b0;
    emit_cmd.bound  = bound_q;
    emit_cmd.shift  = 1'b0;
    emit_cmd.finish = 1'b0;
    case (state_q)
      abre_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = abre_pkg::PROB_INIT;
      end
      abre_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        load       = s_tvalid_i;
      end
      abre_pkg::ST_REDUCE: begin
        red_sub = red_ge;
        rd_en   = !red_ge;
      end
      abre_pkg::ST_UPD: begin
        upd          = 1'b1;
        wr_en        = 1'b1;
        emit_cmd.add = b_cur;
        advance      = !last_bit;
        rd_en        = !last_bit;
      end
      abre_pkg::ST_NORM, abre_pkg::ST_FLUSH: begin
        emit_cmd.shift = 1'b1;
      end
      abre_pkg::ST_FINISH: begin
        emit_cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign shift_go = emit_cmd.shift && !emit_status.stall;

  always_comb begin
    range_d = range_q;
    if (upd) begin
      range_d = range_upd;
    end else if (shift_go && (state_q == abre_pkg::ST_NORM)) begin
      range_d = range_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abre_pkg::ST_CLEAR;
      clr_q       <= '0;
      range_q     <= abre_pkg::RANGE_INIT;
      more_q      <= 1'b0;
      guard_q     <= 2'd0;
      flush_cnt_q <= 3'd0;
    end else begin
      state_q <= state_d;
      range_q <= range_d;
      if (state_q == abre_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (upd) begin
        more_q  <= !last_bit;
        guard_q <= 2'd0;
      end else if (shift_go) begin
        guard_q <= guard_q + 2'd1;
      end
      if (load) begin
        flush_cnt_q <= 3'd0;
      end else if (shift_go && (state_q == abre_pkg::ST_FLUSH)) begin
        flush_cnt_q <= flush_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_q    <= red_d;
    single_q <= single_d;
    bitv_q   <= bitv_d;
    sym_q    <= sym_d;
    mb_q     <= mb_d;
    node_q   <= node_d;
    offs_q   <= offs_d;
    cnt_q    <= cnt_d;
    if (rd_en) begin
      cur_addr_q <= rd_addr;
    end
    if (state_q == abre_pkg::ST_MUL) begin
      bound_q <= prod;
    end
  end

  abre_ram #(
    .WIDTH (abre_pkg::PROB_BITS),
    .DEPTH (PROB_ENTRIES)
  ) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  abre_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (emit_cmd),
    .status_o   (emit_status),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // Between items the range is always normalised.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abre_pkg::ST_IDLE) |-> (range_q >= abre_pkg::TOP_VALUE))
    else $error("range left below the normalisation threshold between items");

  // The look-ahead read of the next tree node never hits the entry being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("probability read and write collide on one entry");

  // An item never ends with an output word still held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abre_pkg::ST_IDLE) |-> !emit_status.held_v)
    else $error("output word held across an item boundary");

endmodule

`default_nettype wire
